// ===== src/crc8frl_pkg.sv =====
// Shared types, codes and the CRC-8 lookup table for the framed register link.
package crc8frl_pkg;

   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CMD_LAST_LO = 8'h06;
   localparam logic [7:0] CMD_FIRST_HI = 8'h08;
   localparam logic [7:0] CMD_LAST_HI = 8'h0B;
   localparam logic [7:0] CMD_WIDE_EXTRA = 8'h17;

   // request operations
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RX    = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_CRC_SEND  = 2'd0;
   localparam logic [1:0] KIND_READ_DONE = 2'd1;
   localparam logic [1:0] KIND_ECHO_DONE = 2'd2;

   // link phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_READ1 = 2'd1;
   localparam logic [1:0] PH_READ2 = 2'd2;
   localparam logic [1:0] PH_ECHO  = 2'd3;

   typedef logic [7:0] crc_table_type [256];

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] value;
      logic        crc_ok;
   } result_type;

   function automatic crc_table_type crc8_build_table();
      crc_table_type t;
      logic [7:0]    c;
      for (int i = 0; i < 256; i++) begin
         c = i[7:0];
         for (int j = 0; j < 8; j++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_table_type CRC8_TABLE = crc8_build_table();

   function automatic logic is_two_byte_cmd(input logic [7:0] cmd);
      return (cmd <= CMD_LAST_LO) ||
             ((cmd >= CMD_FIRST_HI) && (cmd <= CMD_LAST_HI)) ||
             (cmd == CMD_WIDE_EXTRA);
   endfunction

endpackage

// ===== src/crc8frl_ctrl.sv =====
// Link state registers and per-request next-state and response logic.
module crc8frl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  logic [1:0]             req_operation,
   input  logic [7:0]             req_byte_value,
   input  logic [7:0]             req_data_byte,
   output crc8frl_pkg::result_type result
);
   import crc8frl_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  crc_ff, crc_in;
   logic [1:0]  left_ff, left_in;
   logic [15:0] asm_ff, asm_in;
   logic [7:0]  first_crc;

   assign first_crc = CRC8_TABLE[req_byte_value];

   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      left_in  = left_ff;
      asm_in   = asm_ff;
      result   = '0;
      if (req_accept) begin
         case (req_operation)
            OP_READ: begin
               crc_in = first_crc;
               asm_in = '0;
               if (is_two_byte_cmd(req_byte_value)) begin
                  phase_in = PH_READ2;
                  left_in  = 2'd3;
               end else begin
                  phase_in = PH_READ1;
                  left_in  = 2'd2;
               end
            end
            OP_WRITE: begin
               crc_in        = CRC8_TABLE[first_crc ^ req_data_byte];
               phase_in      = PH_ECHO;
               left_in       = 2'd0;
               result.valid  = 1'b1;
               result.kind   = KIND_CRC_SEND;
               result.value  = {8'h00, crc_in};
               result.crc_ok = 1'b1;
            end
            OP_RX: begin
               if (phase_ff == PH_ECHO) begin
                  phase_in      = PH_IDLE;
                  result.valid  = 1'b1;
                  result.kind   = KIND_ECHO_DONE;
                  result.crc_ok = (req_byte_value == crc_ff);
               end else if (phase_ff != PH_IDLE) begin
                  // last byte of a read frame is the CRC
                  if (left_ff <= 2'd1) begin
                     phase_in      = PH_IDLE;
                     left_in       = 2'd0;
                     result.valid  = 1'b1;
                     result.kind   = KIND_READ_DONE;
                     result.value  = asm_ff;
                     result.crc_ok = (req_byte_value == crc_ff);
                  end else begin
                     if ((phase_ff == PH_READ2) && (left_ff == 2'd2)) begin
                        asm_in = {req_byte_value, asm_ff[7:0]};
                     end else begin
                        asm_in = {8'h00, req_byte_value};
                     end
                     crc_in  = CRC8_TABLE[crc_ff ^ req_byte_value];
                     left_in = left_ff - 2'd1;
                  end
               end
            end
            default: begin
               // unused code: drop
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         crc_ff   <= '0;
         left_ff  <= '0;
         asm_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         left_ff  <= left_in;
         asm_ff   <= asm_in;
      end
   end

endmodule

// ===== src/crc8frl_out.sv =====
// Response output register with stall handling.
module crc8frl_out (
   input  logic                   clock,
   input  logic                   reset,
   input  crc8frl_pkg::result_type result,
   output logic                   hold,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [15:0]            rsp_value,
   output logic                   rsp_crc_ok
);
   import crc8frl_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [15:0] value_ff;
   logic        ok_ff;
   logic        load;

   // a full register that is stalled cannot take a new response
   assign hold     = valid_ff && rsp_stall;
   assign load     = result.valid;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= result.kind;
         value_ff <= result.value;
         ok_ff    <= result.crc_ok;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_value  = value_ff;
   assign rsp_crc_ok = ok_ff;

endmodule

// ===== src/crc8_framed_register_link_core.sv =====
// Top level of the CRC-8 framed register link, host side.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  operation, byte_value, data_byte
//   rsp       out         rsp_valid / rsp_stall  kind, value, crc_ok
//
// One request per cycle while req_stall is low; a response appears in the
// cycle after the request that causes it, through the response register.
// The link state updates in the accept cycle via one or two CRC table lookups.
// Reset returns the link to idle with a cleared CRC and empty response register.
// req_stall rises only while a response is held and rsp_stall is high.
module crc8_framed_register_link_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_byte_value,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_value,
   output logic        rsp_crc_ok
);
   import crc8frl_pkg::*;

   result_type result;
   logic       hold;
   logic       req_accept;

   assign req_stall  = hold;
   assign req_accept = req_valid && !hold;

   crc8frl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .req_operation  (req_operation),
      .req_byte_value (req_byte_value),
      .req_data_byte  (req_data_byte),
      .result         (result)
   );

   crc8frl_out u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .hold       (hold),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_kind   (rsp_kind),
      .rsp_value  (rsp_value),
      .rsp_crc_ok (rsp_crc_ok)
   );

endmodule
